// ===== design/cfla_pkg.sv =====
// Package for the chunk free-list allocator: constants, codes and payload types.
package cfla_pkg;

  localparam int CHUNK_COUNT = 1024;
  localparam int LINK_W      = $clog2(CHUNK_COUNT + 1);
  localparam int COUNT_W     = 11;
  localparam int HEAD_W      = 10;

  localparam logic [LINK_W-1:0]  SENTINEL      = LINK_W'(CHUNK_COUNT);
  localparam logic [COUNT_W-1:0] RESERVE_RESET = COUNT_W'(16);

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_COUNT_ZERO = 2'd1,
    ERR_NO_MEMORY  = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [COUNT_W-1:0]  count;
    logic [HEAD_W-1:0]   head_chunk;
  } cmd_t;

  typedef struct packed {
    logic [LINK_W-1:0]   result_chunk;
    err_code_t           error_code;
    logic [COUNT_W-1:0]  chunks_free;
  } result_t;

endpackage

// ===== design/chunk_free_list_allocator_unit.sv =====
// Chunk free-list allocator: link memory, list walker and result register.
// Timing: a request with count zero or out of memory gives its result in the cycle after
//   the transaction; any other request walks its run in ST_WALK, one link per cycle.
// Busy stays high for the whole walk, so no new request is taken until the walk ends.
// Reset: synchronous; after rst the link memory is swept one entry a cycle
//   (entries 0 to CHUNK_COUNT) with busy high. Config writes are taken at any time.
// Results appear for exactly one cycle with done high; the receiver cannot stall.
module chunk_free_list_allocator_unit import cfla_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cmd_t                cmd,
  output logic                done,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data
);

  // Link memory: entry i names the successor of chunk i; entry CHUNK_COUNT is the sentinel.
  logic [LINK_W-1:0] link_mem [0:CHUNK_COUNT];
  logic [LINK_W-1:0] rdata;

  state_t             state, state_next;
  logic [LINK_W-1:0]  pos, pos_next;             // chunk being read; clear index in ST_CLEAR
  logic [LINK_W-1:0]  run_head, run_head_next;   // first chunk of the run in flight
  logic [COUNT_W-1:0] remaining, remaining_next; // links still to walk
  kind_t              kind, kind_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [LINK_W-1:0]  free_head, free_head_next;
  logic [COUNT_W-1:0] available, available_next;
  logic [COUNT_W-1:0] reserve;
  result_t            result_next;
  logic               done_next;

  logic               mem_we;
  logic [LINK_W-1:0]  mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic [LINK_W-1:0]  rd_addr;

  logic [LINK_W-1:0]  req_head;
  logic [COUNT_W:0]   need;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Allocation starts from the free-list head; a free starts from the given chunk.
  assign req_head = (cmd.kind == KIND_ALLOC) ? free_head : {1'b0, cmd.head_chunk};
  assign need     = {1'b0, cmd.count} + {1'b0, reserve};

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    run_head_next  = run_head;
    remaining_next = remaining;
    kind_next      = kind;
    count_next     = count;
    free_head_next = free_head;
    available_next = available;
    result_next    = result;
    done_next      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = pos;
    mem_wdata      = pos + LINK_W'(1);
    rd_addr        = rdata;

    case (state)
      ST_CLEAR: begin
        // Sweep the link memory into one list 0 -> 1 -> ... -> sentinel.
        mem_we = 1'b1;
        if (pos == SENTINEL) begin
          mem_wdata  = SENTINEL;
          state_next = ST_IDLE;
        end else begin
          pos_next = pos + LINK_W'(1);
        end
      end

      ST_IDLE: begin
        // Prefetch the successor of the run head while the request is checked.
        rd_addr = req_head;
        if (start) begin
          if (cmd.count == '0) begin
            result_next = '{result_chunk: SENTINEL, error_code: ERR_COUNT_ZERO,
                            chunks_free: available};
            done_next   = 1'b1;
          end else if (cmd.kind == KIND_ALLOC && {1'b0, available} < need) begin
            result_next = '{result_chunk: SENTINEL, error_code: ERR_NO_MEMORY,
                            chunks_free: available};
            done_next   = 1'b1;
          end else begin
            pos_next       = req_head;
            run_head_next  = req_head;
            remaining_next = cmd.count - COUNT_W'(1);
            kind_next      = cmd.kind;
            count_next     = cmd.count;
            state_next     = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // rdata holds the successor of pos.
        if (remaining == '0) begin
          // pos is the tail of the run: close it and splice the list.
          mem_we    = 1'b1;
          mem_waddr = pos;
          if (kind == KIND_ALLOC) begin
            mem_wdata      = run_head;
            free_head_next = rdata;
            available_next = available - count;
          end else begin
            mem_wdata      = free_head;
            free_head_next = run_head;
            available_next = available + count;
          end
          result_next = '{result_chunk: (kind == KIND_ALLOC) ? run_head : SENTINEL,
                          error_code: ERR_OK, chunks_free: available_next};
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          // Advance one link and read the next successor.
          pos_next       = rdata;
          remaining_next = remaining - COUNT_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pos       <= '0;
      free_head <= '0;
      available <= COUNT_W'(CHUNK_COUNT);
      reserve   <= RESERVE_RESET;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      free_head <= free_head_next;
      available <= available_next;
      done      <= done_next;
      if (cfg_valid && cfg_ready) begin
        reserve <= cfg_data;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    run_head  <= run_head_next;
    remaining <= remaining_next;
    kind      <= kind_next;
    count     <= count_next;
    result    <= result_next;
  end

  // Link memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= link_mem[rd_addr];
  end

endmodule
